>>> rtl/lifo_stack_with_search_top_assert.svh
// ----------------------------------------------------------------------------
// lifo_stack_with_search_top_assert.svh
// Assertion macros for the search stack; empty bodies when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_SEARCH_TOP_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define LSWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("stack assertion failed");
// antecedent implies consequent in the next cycle
`define LSWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("stack assertion failed");
`else
`define LSWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LSWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/lsws_pkg.sv
// ----------------------------------------------------------------------------
// lsws_pkg
// Types and request/status codes shared by the search stack modules.
// ----------------------------------------------------------------------------
package lsws_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic [1:0]         req_t;
	typedef logic [1:0]         status_t;

	localparam req_t REQ_PUSH   = 2'd0;
	localparam req_t REQ_POP    = 2'd1;
	localparam req_t REQ_PEEK   = 2'd2;
	localparam req_t REQ_SEARCH = 2'd3;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;
	localparam status_t ST_NOT_FOUND = 2'd3;

endpackage

>>> rtl/lifo_stack_with_search_top.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search_top
// Bounded LIFO of signed 32-bit words with push, pop, peek and search.
// ----------------------------------------------------------------------------
// Request channel: req_valid/req_stall carry req_type and value. Response
// channel: rsp_valid/rsp_stall carry out_value, status, is_empty and
// fill_count. Every request beat yields exactly one response beat, in order.
// Push, and any request that fails at once (full, empty), completes in the
// accept cycle: a new request can follow in the next cycle, so one per
// cycle unless a stalled output holds it off. Pop and peek read the
// registered entry memory and finish in S_READ. Search walks the memory
// from the bottom, one entry a cycle, stopping at the first match.
// Results pass a one-deep result stage and then the output register, so a
// new request is taken while a response waits. When rsp_stall holds both
// full, req_stall rises until the output drains.
// Reset clears the count, the control state and both valid flags; the entry
// memory is not cleared and no entry is read before it has been pushed.
// fill_count is the count held after the request, taken modulo 32.
// ----------------------------------------------------------------------------
`include "lifo_stack_with_search_top_assert.svh"

module lifo_stack_with_search_top #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  lsws_pkg::req_t     req_type,
	input  lsws_pkg::word_t    value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output lsws_pkg::word_t    out_value,
	output lsws_pkg::status_t  status,
	output logic               is_empty,
	output logic [4:0]         fill_count
);
	import lsws_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic [1:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d, top_idx;
	logic          full, empty, acc;

	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	word_t         ram_rdata;

	logic [AW-1:0] scan_addr_q;
	logic          scan_on_q, scan_last, scan_start, scan_done;
	logic          cmp_vld_s1, cmp_last_s1;
	word_t         key_q;

	logic          res_ld, res_move, res_pend_q;
	word_t         res_val_d, res_val_q;
	status_t       res_st_d, res_st_q;
	logic [CW-1:0] res_cnt_q;
	logic [CW+4:0] fc_ext;

	logic          rsp_valid_q;
	word_t         out_value_q;
	status_t       status_q;
	logic          is_empty_q;
	logic [4:0]    fill_count_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign top_idx = cnt_q - CW'(1);

	assign res_move  = res_pend_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = !((state_q == S_IDLE) && (!res_pend_q || res_move));
	assign acc       = req_valid && !req_stall;
	assign scan_last = (CW'(scan_addr_q) == top_idx);

	lsws_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ram_we     = 1'b0;
		ram_raddr  = top_idx[AW-1:0];
		res_ld     = 1'b0;
		res_val_d  = '0;
		res_st_d   = ST_OK;
		scan_start = 1'b0;
		scan_done  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req_type)
						REQ_PUSH: begin
							res_ld = 1'b1;
							if (full) begin
								res_st_d = ST_OVERFLOW;
							end else begin
								ram_we = 1'b1;
								cnt_d  = cnt_q + CW'(1);
							end
						end
						REQ_POP: begin
							if (empty) begin
								res_ld   = 1'b1;
								res_st_d = ST_UNDERFLOW;
							end else begin
								cnt_d   = top_idx;
								state_d = S_READ;
							end
						end
						REQ_PEEK: begin
							if (empty) begin
								res_ld   = 1'b1;
								res_st_d = ST_UNDERFLOW;
							end else begin
								state_d = S_READ;
							end
						end
						default: begin
							if (empty) begin
								res_ld   = 1'b1;
								res_st_d = ST_NOT_FOUND;
							end else begin
								scan_start = 1'b1;
								state_d    = S_SCAN;
							end
						end
					endcase
				end
			end
			S_READ: begin
				res_ld    = 1'b1;
				res_val_d = ram_rdata;
				state_d   = S_IDLE;
			end
			S_SCAN: begin
				ram_raddr = scan_addr_q;
				if (cmp_vld_s1 && (ram_rdata == key_q)) begin
					res_ld    = 1'b1;
					scan_done = 1'b1;
					state_d   = S_IDLE;
				end else if (cmp_vld_s1 && cmp_last_s1) begin
					res_ld    = 1'b1;
					res_st_d  = ST_NOT_FOUND;
					scan_done = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			scan_on_q   <= 1'b0;
			scan_addr_q <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			res_pend_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;

			if (scan_start) begin
				scan_addr_q <= '0;
				scan_on_q   <= 1'b1;
				cmp_vld_s1  <= 1'b0;
			end else if (state_q == S_SCAN) begin
				if (scan_done) begin
					scan_on_q  <= 1'b0;
					cmp_vld_s1 <= 1'b0;
				end else begin
					cmp_vld_s1  <= scan_on_q;
					cmp_last_s1 <= scan_last;
					if (scan_on_q) begin
						if (scan_last) begin
							scan_on_q <= 1'b0;
						end else begin
							scan_addr_q <= scan_addr_q + AW'(1);
						end
					end
				end
			end

			if (res_ld) begin
				res_pend_q <= 1'b1;
			end else if (res_move) begin
				res_pend_q <= 1'b0;
			end

			if (res_move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign fc_ext = (CW + 5)'(res_cnt_q);

	always_ff @(posedge clk) begin
		if (scan_start) begin
			key_q <= value;
		end
		if (res_ld) begin
			res_val_q <= res_val_d;
			res_st_q  <= res_st_d;
			res_cnt_q <= cnt_d;
		end
		if (res_move) begin
			out_value_q  <= res_val_q;
			status_q     <= res_st_q;
			is_empty_q   <= (res_cnt_q == '0);
			fill_count_q <= fc_ext[4:0];
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign out_value  = out_value_q;
	assign status     = status_q;
	assign is_empty   = is_empty_q;
	assign fill_count = fill_count_q;

	`LSWS_ASSERT_IMPLY(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))
	`LSWS_ASSERT_IMPLY(a_res_free_busy, clk, arst_n, state_q != S_IDLE, !res_pend_q)
	`LSWS_ASSERT_NEXT(a_push_cnt, clk, arst_n, acc && (req_type == REQ_PUSH) && !full, cnt_q == $past(cnt_q) + CW'(1))
	`LSWS_ASSERT_IMPLY(a_cmp_in_scan, clk, arst_n, cmp_vld_s1, state_q == S_SCAN)
	`LSWS_ASSERT_NEXT(a_read_done, clk, arst_n, state_q == S_READ, (state_q == S_IDLE) && res_pend_q)

endmodule

>>> rtl/lsws_ram.sv
// ----------------------------------------------------------------------------
// lsws_ram
// Stack entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lsws_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  lsws_pkg::word_t       wdata,
	input  logic [AW-1:0]         raddr,
	output lsws_pkg::word_t       rdata
);
	import lsws_pkg::*;

	word_t mem [DEPTH];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> bench/tb_lifo_stack_with_search_top.sv
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search_top
// Self-checking bench for the search stack: push, pop, peek and search.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a falling-edge driver that sends in
// bursts with random gaps. Requests go in directed first, then in two random
// phases. Each accepted request beat runs through a local stack model. Every
// response beat is checked field by field against the oldest predicted
// result. The response side stalls in changing patterns. One long hold-off
// fills the block while requests keep coming. Between phases the sender
// waits until every predicted result has arrived.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_search_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lsws_pkg::*;

	localparam int STACK_DEPTH  = 16;
	localparam int ITEM_TOTAL   = 1850;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 24;
	localparam int LONG_HOLD    = 80;
	localparam int POOL_SIZE    = 12;

	typedef struct {
		req_t  kind;
		word_t word;
	} stack_req_t;

	typedef struct {
		word_t      word;
		status_t    st;
		logic       empty;
		logic [4:0] fill;
	} stack_rsp_t;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_t       req_type;
	word_t      value;
	logic       rsp_valid;
	logic       rsp_stall;
	word_t      out_value;
	status_t    status;
	logic       is_empty;
	logic [4:0] fill_count;

	stack_req_t pending_req_q[$];
	stack_rsp_t rsp_due_q[$];

	// local stack model
	word_t model_mem[STACK_DEPTH];
	int    model_fill;

	word_t value_pool[POOL_SIZE];
	mix_t  mix_mode;
	int    mix_left;

	bit    req_taken;
	int    gap_left;
	int    burst_left;
	int    rx_hold_left;
	bit    hold_kick;
	int    rx_mode;
	int    rx_mode_left;
	int    fail_cnt;
	int    cycle_cnt;

	lifo_stack_with_search_top #(
		.DEPTH(STACK_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.out_value  (out_value),
		.status     (status),
		.is_empty   (is_empty),
		.fill_count (fill_count)
	);

	always #5 clk = ~clk;

	function automatic stack_rsp_t apply_stack_req(stack_req_t r);
		stack_rsp_t res;
		res.word = '0;
		res.st   = ST_OK;
		case (r.kind)
			REQ_PUSH: begin
				if (model_fill >= STACK_DEPTH) begin
					res.st = ST_OVERFLOW;
				end else begin
					model_mem[model_fill] = r.word;
					model_fill++;
				end
			end
			REQ_POP: begin
				if (model_fill == 0) begin
					res.st = ST_UNDERFLOW;
				end else begin
					model_fill--;
					res.word = model_mem[model_fill];
				end
			end
			REQ_PEEK: begin
				if (model_fill == 0)
					res.st = ST_UNDERFLOW;
				else
					res.word = model_mem[model_fill - 1];
			end
			default: begin
				res.st = ST_NOT_FOUND;
				for (int i = 0; i < model_fill; i++) begin
					if (model_mem[i] == r.word) begin
						res.st = ST_OK;
						break;
					end
				end
			end
		endcase
		res.empty = (model_fill == 0);
		res.fill  = 5'(model_fill);
		return res;
	endfunction

	task automatic queue_req(req_t kind, word_t word);
		stack_req_t r;
		r.kind = kind;
		r.word = word;
		pending_req_q.push_back(r);
	endtask

	function automatic word_t pick_word();
		if ($urandom_range(0, 9) < 6)
			return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		return word_t'($urandom);
	endfunction

	// segments biased towards filling, draining or neither, so full and empty
	// are both reached often
	task automatic queue_random_reqs(int n);
		int   roll;
		req_t kind;
		for (int k = 0; k < n; k++) begin
			if (mix_left == 0) begin
				mix_left = $urandom_range(8, 40);
				case ($urandom_range(0, 2))
					0: mix_mode = MIX_FILL;
					1: mix_mode = MIX_DRAIN;
					default: mix_mode = MIX_EVEN;
				endcase
			end
			mix_left--;
			roll = $urandom_range(0, 99);
			case (mix_mode)
				MIX_FILL: kind = (roll < 70) ? REQ_PUSH : (roll < 80) ? REQ_POP :
					(roll < 90) ? REQ_PEEK : REQ_SEARCH;
				MIX_DRAIN: kind = (roll < 15) ? REQ_PUSH : (roll < 75) ? REQ_POP :
					(roll < 85) ? REQ_PEEK : REQ_SEARCH;
				default: kind = (roll < 35) ? REQ_PUSH : (roll < 60) ? REQ_POP :
					(roll < 75) ? REQ_PEEK : REQ_SEARCH;
			endcase
			queue_req(kind, pick_word());
		end
	endtask

	task automatic wait_all_answered();
		while (pending_req_q.size() != 0 || req_valid || rsp_due_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	// request driver
	always @(negedge clk) begin
		stack_req_t r;
		if (req_valid && !req_taken) begin
			// beat still stalled: hold payload
		end else begin
			req_taken = 1'b0;
			if (gap_left > 0 && rx_hold_left == 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_req_q.size() > 0) begin
				r = pending_req_q.pop_front();
				req_valid <= 1'b1;
				req_type  <= r.kind;
				value     <= r.word;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left   = ($urandom_range(0, 9) < 4) ? 0 :
						($urandom_range(0, 9) == 0) ? 15 : $urandom_range(1, 6);
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response stall pattern
	always @(negedge clk) begin
		if (hold_kick) begin
			hold_kick = 1'b0;
			rx_hold_left <= LONG_HOLD;
			rsp_stall    <= 1'b1;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			rsp_stall    <= 1'b1;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode_left = $urandom_range(4, 50);
				rx_mode      = $urandom_range(0, 3);
			end
			rx_mode_left--;
			case (rx_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				2: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= ~rsp_stall;
			endcase
		end
	end

	// request beats feed the model, response beats are checked
	always @(posedge clk) begin
		stack_req_t r;
		stack_rsp_t want;
		if (req_valid === 1'b1 && req_stall === 1'b0) begin
			r.kind = req_type;
			r.word = value;
			rsp_due_q.push_back(apply_stack_req(r));
			req_taken = 1'b1;
		end
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (rsp_due_q.size() == 0) begin
				$display("%0t: response beat with nothing expected, actual %0h %0h %0b %0d",
					$time, out_value, status, is_empty, fill_count);
				fail_cnt++;
			end else begin
				want = rsp_due_q.pop_front();
				report_field("out_value", want.word, out_value);
				report_field("status", 32'(want.st), 32'(status));
				report_field("is_empty", 32'(want.empty), 32'(is_empty));
				report_field("fill_count", 32'(want.fill), 32'(fill_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("lifo_stack_with_search_top test failed");
			$finish;
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req_type     = REQ_PUSH;
		value        = '0;
		rsp_stall    = 1'b0;
		model_fill   = 0;
		mix_mode     = MIX_EVEN;
		mix_left     = 0;
		req_taken    = 1'b0;
		gap_left     = 0;
		burst_left   = 0;
		rx_hold_left = 0;
		hold_kick    = 1'b0;
		rx_mode      = 0;
		rx_mode_left = 0;
		fail_cnt     = 0;
		cycle_cnt    = 0;
		foreach (model_mem[i])
			model_mem[i] = '0;
		value_pool[0] = 32'sh0000_0000;
		value_pool[1] = 32'shFFFF_FFFF;
		value_pool[2] = 32'sh7FFF_FFFF;
		value_pool[3] = 32'sh8000_0000;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = word_t'($urandom);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases, extremes, search hit and miss, fill to overflow
		queue_req(REQ_POP, 32'sh1234_5678);
		queue_req(REQ_PEEK, 32'shFFFF_FFFF);
		queue_req(REQ_SEARCH, 32'sh0000_0000);
		queue_req(REQ_PUSH, 32'sh7FFF_FFFF);
		queue_req(REQ_PUSH, 32'sh8000_0000);
		queue_req(REQ_SEARCH, 32'sh8000_0000);
		queue_req(REQ_SEARCH, 32'sh0000_0005);
		queue_req(REQ_PEEK, 32'sh0000_0000);
		queue_req(REQ_POP, 32'sh0000_0000);
		queue_req(REQ_PUSH, 32'shFFFF_FFFF);
		queue_req(REQ_PUSH, 32'sh0000_0000);
		for (int i = 0; i < 13; i++)
			queue_req(REQ_PUSH, (i % 4 == 0) ? 32'shFFFF_FFFF : word_t'($urandom));
		queue_req(REQ_PUSH, 32'sh5555_AAAA);
		queue_req(REQ_SEARCH, 32'shFFFF_FFFF);
		queue_req(REQ_PEEK, 32'sh0000_0000);
		wait_all_answered();

		queue_random_reqs(900);
		wait_all_answered();

		// keep requests coming through a long response hold-off
		queue_random_reqs(60);
		hold_kick = 1'b1;
		queue_random_reqs(ITEM_TOTAL - 27 - 960);
		wait_all_answered();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && rsp_due_q.size() == 0)
			$display("lifo_stack_with_search_top test passed");
		else
			$display("lifo_stack_with_search_top test failed");
		$finish;
	end

endmodule
